// ===== hdl/lzx_pkg.sv =====
// Shared constants, types and the controller/datapath interface for the decompressor.
`timescale 1ns / 1ps
package lzx_pkg;

  localparam int WinAw          = 13;
  localparam int WinDepth       = 1 << WinAw;
  localparam int BytesPerResult = 4;

  typedef enum logic [3:0] {
    PH_FLAG1,
    PH_FLAG2,
    PH_SHORT_A,
    PH_SHORT_B,
    PH_LITERAL,
    PH_LONG_LO,
    PH_LONG_HI,
    PH_LONG_CNT,
    PH_SHORT_OFF,
    PH_DONE
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             restart;
    logic             lit;
    logic             copy;
    logic             fin;
    logic [7:0]       data;
    logic [8:0]       len;
    logic [WinAw-1:0] match_dist;
  } lzx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic free;
  } lzx_sts_t;

endpackage

// ===== hdl/lzx_ctrl.sv =====
// Decoder controller: flag word handling, decode phases and command issue.
`timescale 1ns / 1ps
module lzx_ctrl import lzx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  input  logic       new_stream,
  input  lzx_sts_t   sts,
  output lzx_cmd_t   cmd
);

  typedef enum logic {C_IDLE, C_BITS} ctl_state_t;

  ctl_state_t  state, state_next;
  phase_t      phase, phase_next;
  logic [15:0] flag_word, flag_word_next;
  logic [4:0]  flags_left, flags_left_next;
  logic [7:0]  held, held_next;
  logic [8:0]  mlen, mlen_next;
  logic        low_taken, low_taken_next;

  // The long match distance comes from the header bytes, kept until the count byte.
  logic [WinAw-1:0] dist_keep, dist_keep_next;

  phase_t      e_phase;
  logic [4:0]  e_flags_left;
  logic        e_low_taken;
  logic        take;

  assign in_ready = (state == C_IDLE) && sts.free;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    flag_word_next  = flag_word;
    flags_left_next = flags_left;
    held_next       = held;
    mlen_next       = mlen;
    low_taken_next  = low_taken;
    cmd             = '0;
    e_phase         = new_stream ? PH_FLAG1 : phase;
    e_flags_left    = new_stream ? 5'd0 : flags_left;
    e_low_taken     = new_stream ? 1'b0 : low_taken;

    if (state == C_BITS) begin
      if (flags_left != 5'd0 && phase <= PH_SHORT_B) begin
        flag_word_next  = {1'b0, flag_word[15:1]};
        flags_left_next = flags_left - 5'd1;
        unique case (phase)
          PH_FLAG1:   phase_next = flag_word[0] ? PH_LITERAL : PH_FLAG2;
          PH_FLAG2:   phase_next = flag_word[0] ? PH_LONG_LO : PH_SHORT_A;
          PH_SHORT_A: begin
            mlen_next  = {7'd0, flag_word[0], 1'b0};
            phase_next = PH_SHORT_B;
          end
          default: begin
            mlen_next  = mlen + {8'd0, flag_word[0]} + 9'd2;
            phase_next = PH_SHORT_OFF;
          end
        endcase
      end else begin
        state_next = C_IDLE;
      end
    end else if (take) begin
      cmd.restart = new_stream;
      cmd.data    = stream_byte;
      if (new_stream) begin
        flag_word_next = '0;
        held_next      = '0;
        mlen_next      = '0;
        phase_next     = PH_FLAG1;
        flags_left_next = '0;
        low_taken_next = 1'b0;
      end
      if (e_phase == PH_DONE) begin
        // Nothing is decoded after the end marker.
      end else if (e_flags_left == 5'd0) begin
        if (!e_low_taken) begin
          held_next      = stream_byte;
          low_taken_next = 1'b1;
        end else begin
          flag_word_next  = {stream_byte, held};
          flags_left_next = 5'd16;
          low_taken_next  = 1'b0;
          state_next      = C_BITS;
        end
      end else begin
        unique case (e_phase)
          PH_LITERAL: begin
            cmd.lit    = 1'b1;
            phase_next = PH_FLAG1;
            state_next = C_BITS;
          end
          PH_LONG_LO: begin
            held_next  = stream_byte;
            phase_next = PH_LONG_HI;
          end
          PH_LONG_HI: begin
            cmd.match_dist = {stream_byte[7:3], held};
            if (stream_byte[2:0] == 3'd0) begin
              phase_next = PH_LONG_CNT;
            end else begin
              cmd.copy   = 1'b1;
              cmd.len    = {6'd0, stream_byte[2:0]} + 9'd2;
              phase_next = PH_FLAG1;
              state_next = C_BITS;
            end
          end
          PH_LONG_CNT: begin
            cmd.match_dist = dist_keep;
            if (stream_byte == 8'd0) begin
              cmd.fin    = 1'b1;
              phase_next = PH_DONE;
            end else begin
              // A count of one marks a segment boundary and copies nothing.
              cmd.copy   = (stream_byte != 8'd1);
              cmd.len    = {1'b0, stream_byte} + 9'd1;
              phase_next = PH_FLAG1;
              state_next = C_BITS;
            end
          end
          default: begin
            cmd.copy       = 1'b1;
            cmd.match_dist = {5'h1F, stream_byte};
            cmd.len        = mlen;
            phase_next     = PH_FLAG1;
            state_next     = C_BITS;
          end
        endcase
      end
    end
  end

  always_comb begin
    dist_keep_next = dist_keep;
    if (state == C_IDLE && take && e_phase == PH_LONG_HI && e_flags_left != 5'd0) begin
      dist_keep_next = {stream_byte[7:3], held};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= C_IDLE;
      phase      <= PH_FLAG1;
      flag_word  <= '0;
      flags_left <= '0;
      held       <= '0;
      mlen       <= '0;
      low_taken  <= 1'b0;
      dist_keep  <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      flag_word  <= flag_word_next;
      flags_left <= flags_left_next;
      held       <= held_next;
      mlen       <= mlen_next;
      low_taken  <= low_taken_next;
      dist_keep  <= dist_keep_next;
    end
  end

endmodule

// ===== hdl/lzx_dpath.sv =====
// Datapath: history window, match copy engine, result packing and output register.
`timescale 1ns / 1ps
module lzx_dpath import lzx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lzx_cmd_t    cmd,
  output lzx_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data,
  output logic [2:0]  byte_count,
  output logic        run_last,
  output logic        stream_end
);

  typedef enum logic [1:0] {CP_IDLE, CP_RD, CP_WR, CP_FLUSH} cp_state_t;

  logic [7:0]       hist [WinDepth];
  logic [7:0]       rd_data;
  logic             rd_ok;
  cp_state_t        cp_state;
  logic [WinAw-1:0] wp, cp_dist, src;
  logic             wrapped;
  logic [8:0]       remaining;
  logic [2:0]       filled;
  logic [31:0]      pack;
  logic             mem_we;
  logic [7:0]       mem_wd, cp_byte;
  logic             out_free;
  logic             out_load;

  assign src      = wp + cp_dist;
  assign cp_byte  = rd_ok ? rd_data : 8'd0;
  assign mem_we   = cmd.lit || (cp_state == CP_WR);
  assign mem_wd   = cmd.lit ? cmd.data : cp_byte;
  assign out_free = !out_valid || out_ready;
  assign out_load = cmd.lit || cmd.fin || ((cp_state == CP_FLUSH) && out_free);
  assign sts.free = (cp_state == CP_IDLE) && out_free;

  // Entries not yet written since the restart read as zero: the window fills in order.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[wp] <= mem_wd;
    end
    rd_data <= hist[src];
    rd_ok   <= wrapped || (src < wp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_state  <= CP_IDLE;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.restart) begin
        wp      <= '0;
        wrapped <= 1'b0;
      end
      if (cmd.lit) begin
        out_data   <= {24'd0, cmd.data};
        byte_count <= 3'd1;
        run_last   <= 1'b1;
        stream_end <= 1'b0;
      end
      if (cmd.fin) begin
        out_data   <= '0;
        byte_count <= 3'd0;
        run_last   <= 1'b1;
        stream_end <= 1'b1;
      end
      if (mem_we) begin
        wp <= wp + 1'b1;
        if (wp == {WinAw{1'b1}}) begin
          wrapped <= 1'b1;
        end
      end
      unique case (cp_state)
        CP_IDLE: begin
          if (cmd.copy) begin
            cp_dist   <= cmd.match_dist;
            remaining <= cmd.len;
            filled    <= '0;
            pack      <= '0;
            cp_state  <= CP_RD;
          end
        end
        CP_RD: cp_state <= CP_WR;
        CP_WR: begin
          pack[{filled[1:0], 3'b000} +: 8] <= cp_byte;
          filled    <= filled + 3'd1;
          remaining <= remaining - 9'd1;
          if (filled == 3'(BytesPerResult - 1) || remaining == 9'd1) begin
            cp_state <= CP_FLUSH;
          end else begin
            cp_state <= CP_RD;
          end
        end
        default: begin
          if (out_free) begin
            out_data   <= pack;
            byte_count <= filled;
            run_last   <= (remaining == 9'd0);
            stream_end <= 1'b0;
            pack       <= '0;
            filled     <= '0;
            cp_state   <= (remaining == 9'd0) ? CP_IDLE : CP_RD;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/lzexe_stream_decompressor.sv =====
// Top level of the LZEXE stream decompressor.
//   channel  | handshake            | payload
//   input    | in_valid / in_ready  | stream_byte, new_stream
//   output   | out_valid / out_ready| out_data, byte_count, run_last, stream_end
// A header or flag low byte is taken without entering the flag loop. A byte that ends in
// the flag loop (literal, flag high byte, finished match) steps through each flag bit
// used and then leaves it. A match copies one byte at a time, a window read and then a
// write, with a packing flush per result; input is held off until the copy has finished.
// Synchronous reset and a restart request need no clearing pass: unwritten entries read zero.
// A stalled output holds off both the copy engine and the next input request.
`timescale 1ns / 1ps
module lzexe_stream_decompressor import lzx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        new_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data,
  output logic [2:0]  byte_count,
  output logic        run_last,
  output logic        stream_end
);

  lzx_cmd_t cmd;
  lzx_sts_t sts;

  lzx_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .new_stream  (new_stream),
    .sts         (sts),
    .cmd         (cmd)
  );

  lzx_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .byte_count (byte_count),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

endmodule
